// ----- sv/salc_pkg.sv -----
// Shared types, constants and helpers for the set-associative LRU cache unit.
// No dependencies.
`timescale 1ns / 1ps

package salc_pkg;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_ADDR_BITS    = 64;
    localparam int TAG_W            = 64;
    localparam int SETIDX_W         = 6;
    localparam int CNT_W            = 32;
    localparam int OUTCOME_W        = 2;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 6;
    localparam int SB_CFG_W         = 3;
    localparam int BB_CFG_W         = 6;
    localparam int WAYS_CFG_W       = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FILL  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_CLEAR  = 3'b100
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

// ----- sv/salc_set_mem.sv -----
// Set memory: one row per set holding valid, age and tag of every way.
// Depends on salc_pkg.
`timescale 1ns / 1ps

module salc_set_mem
    import salc_pkg::*;
#(
    parameter int SETS  = 64,
    parameter int ROW_W = 8
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(SETS)-1:0]  wr_addr,
    input  logic [ROW_W-1:0]         wr_data,
    input  logic [$clog2(SETS)-1:0]  rd_addr,
    output logic [ROW_W-1:0]         rd_data
);

    logic [ROW_W-1:0] mem [SETS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/set_assoc_lru_cache_sim_unit.sv -----
// Set-associative LRU cache unit: one address per beat, one result beat per item.
// Depends on salc_pkg and salc_set_mem.
`timescale 1ns / 1ps
// Sequence: an accepted start enters LOOKUP with the set row read, and done is registered from LOOKUP.
// Start is taken only in IDLE, so each item's set-memory row is read and written back before the next.
// Reset: clears counters and config to defaults, then sweeps the set memory clearing
// valid bits and ages, one set per cycle over all 2**MAX_SET_BITS sets, busy high.
// The receiver cannot stall: done is a single-cycle strobe.

module set_assoc_lru_cache_sim_unit
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int ADDR_BITS    = DEF_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ADDR_BITS-1:0]  address,
    output logic                  done,
    output logic [OUTCOME_W-1:0]  outcome,
    output logic [SETIDX_W-1:0]   set_id,
    output logic [TAG_W-1:0]      tag_value,
    output logic [CNT_W-1:0]      hit_count,
    output logic [CNT_W-1:0]      miss_count,
    output logic [CNT_W-1:0]      eviction_count,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SETS  = 1 << MAX_SET_BITS;
    localparam int SA_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W = $clog2(MAX_WAYS + 1);
    localparam int ROW_W = MAX_WAYS * (1 + AGE_W + TAG_W);
    localparam int SBW   = $clog2(MAX_SET_BITS + 1);

    typedef struct packed {
        logic [MAX_WAYS-1:0]            valid;
        logic [MAX_WAYS-1:0][AGE_W-1:0] age;
        logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
    } row_t;

    // configuration
    logic [SB_CFG_W-1:0]   set_bits_reg;
    logic [BB_CFG_W-1:0]   block_bits_reg;
    logic [WAYS_CFG_W-1:0] ways_reg;

    state_t state_reg, state_next;
    logic [SA_W-1:0]       clr_reg;
    logic [SA_W-1:0]       set_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [CNT_W-1:0]      hits_reg, misses_reg, evict_reg;

    // address split, done at acceptance
    logic [SBW-1:0]  sb;
    logic [6:0]      total;
    logic [63:0]     addr64;
    logic [63:0]     tag_in;
    logic [63:0]     set_full;
    logic [SA_W-1:0] set_in;

    always_comb
    begin
        sb = (set_bits_reg > SB_CFG_W'(MAX_SET_BITS)) ? SBW'(MAX_SET_BITS)
                                                      : SBW'(set_bits_reg);
        addr64 = 64'(address);
        total  = 7'(sb) + 7'(block_bits_reg);
        tag_in = (total >= 7'd64) ? 64'd0 : (addr64 >> total);
        set_full = (addr64 >> block_bits_reg) & ((64'd1 << sb) - 64'd1);
        set_in = SA_W'(set_full);
    end

    logic             accept;
    logic             mem_we;
    logic [SA_W-1:0]  mem_waddr;
    row_t             mem_wrow, rd_row;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    salc_set_mem #(
        .SETS  (SETS),
        .ROW_W (ROW_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wrow),
        .rd_addr (set_in),
        .rd_data (rd_row)
    );

    // lookup and LRU update on the read row
    logic [WAY_W-1:0]   nw;
    logic               hit, free_found;
    logic [WAY_W-1:0]   hit_way, free_way, victim, sel_way;
    logic [AGE_W-1:0]   limit;
    logic               aged_full;
    row_t               new_row;
    logic [OUTCOME_W-1:0] oc;

    always_comb
    begin
        nw = (ways_reg == '0) ? WAY_W'(1)
           : (ways_reg > WAYS_CFG_W'(MAX_WAYS)) ? WAY_W'(MAX_WAYS) : WAY_W'(ways_reg);
        hit = 1'b0;
        hit_way = '0;
        free_found = 1'b0;
        free_way = '0;
        victim = '0;
        for (int j = MAX_WAYS - 1; j >= 0; j--)
        begin
            if (WAY_W'(j) < nw && rd_row.valid[j] && rd_row.tag[j] == tag_reg)
            begin
                hit = 1'b1;
                hit_way = WAY_W'(j);
            end
            if (WAY_W'(j) < nw && !rd_row.valid[j])
            begin
                free_found = 1'b1;
                free_way = WAY_W'(j);
            end
        end
        for (int j = 1; j < MAX_WAYS; j++)
            if (WAY_W'(j) < nw && rd_row.age[j] > rd_row.age[victim[AGE_W-1:0]])
                victim = WAY_W'(j);
        if (hit)
        begin
            sel_way = hit_way;
            oc = OUT_HIT;
        end
        else if (free_found)
        begin
            sel_way = free_way;
            oc = OUT_FILL;
        end
        else
        begin
            sel_way = victim;
            oc = OUT_EVICT;
        end
        // limit: hit ages only younger lines; misses age all (below max rank)
        limit = rd_row.age[sel_way[AGE_W-1:0]];
        aged_full = !hit;
        new_row = rd_row;
        for (int j = 0; j < MAX_WAYS; j++)
            if (WAY_W'(j) < nw && WAY_W'(j) != sel_way && rd_row.valid[j]
                && (aged_full || rd_row.age[j] < limit)
                && rd_row.age[j] < AGE_W'(MAX_WAYS - 1))
                new_row.age[j] = rd_row.age[j] + 1'b1;
        new_row.age[sel_way[AGE_W-1:0]] = '0;
        new_row.valid[sel_way[AGE_W-1:0]] = 1'b1;
        new_row.tag[sel_way[AGE_W-1:0]] = tag_reg;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = set_reg;
        mem_wrow  = new_row;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wrow  = '0;
        end
        else if (state_reg == ST_LOOKUP)
            mem_we = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_reg == SA_W'(SETS - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (start) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            set_bits_reg   <= SB_CFG_W'(4);
            block_bits_reg <= BB_CFG_W'(4);
            ways_reg       <= WAYS_CFG_W'(1);
            hits_reg       <= '0;
            misses_reg     <= '0;
            evict_reg      <= '0;
            done           <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= (state_reg == ST_LOOKUP);
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SET_BITS:   set_bits_reg   <= cfg_data[SB_CFG_W-1:0];
                    CFG_BLOCK_BITS: block_bits_reg <= cfg_data[BB_CFG_W-1:0];
                    CFG_WAYS:       ways_reg       <= cfg_data[WAYS_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_LOOKUP)
            begin
                if (oc == OUT_HIT)
                    hits_reg <= sat_inc(hits_reg);
                else
                    misses_reg <= sat_inc(misses_reg);
                if (oc == OUT_EVICT)
                    evict_reg <= sat_inc(evict_reg);
            end
        end
    end

    // payload registers: hold the accepted beat and the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg <= set_in;
            tag_reg <= tag_in;
        end
        if (state_reg == ST_LOOKUP)
        begin
            outcome   <= oc;
            set_id    <= SETIDX_W'(set_reg);
            tag_value <= tag_reg;
        end
    end

    assign hit_count      = hits_reg;
    assign miss_count     = misses_reg;
    assign eviction_count = evict_reg;

    a_done_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |=> done)
        else $error("result beat missing after lookup");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted beat did not raise busy");
    a_no_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == ST_LOOKUP)
        else $error("spurious result beat");

endmodule
